FILE: rtl/core/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, character codes and helpers for the infix-to-postfix unit.
// ----------------------------------------------------------------------------
package itp_pkg;

    // Default operator stack depth
    localparam int STACK_DEPTH_DEF = 32;

    // Depth of the command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Precedence levels; an open paren ranks lowest
    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_POW  = 2'd3;

    typedef enum logic [2:0] {
        K_OPERAND,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ch;
        logic [1:0]  prec;
    } t_cmd;

    function automatic logic [1:0] prec_of(input logic [7:0] ch);
        logic [1:0] p;
        case (ch)
            CH_CARET:           p = PREC_POW;
            CH_STAR, CH_SLASH:  p = PREC_MUL;
            CH_PLUS, CH_MINUS:  p = PREC_ADD;
            default:            p = PREC_NONE;
        endcase
        return p;
    endfunction

    function automatic logic is_operand(input logic [7:0] ch);
        return ch inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]};
    endfunction

endpackage

FILE: rtl/core/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: one infix character in per beat, postfix out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one character per beat, or an
//   end marker (i_is_end). Letters and digits pass through, parens and the
//   operators ^ * / + - go through an operator stack, anything else is
//   dropped at the input. An end beat flushes the stack top-down and closes
//   the expression with a zero character marked o_last.
//   Output channel (o_valid / i_stall) carries one postfix character per
//   beat with o_overflow, the sticky stack-full flag; the end beat clears it
//   once its terminator is out.
//   A classifier accepts beats into a two-entry command queue; the stack
//   engine behind it drains the queue, so the input only stalls when the
//   queue is full.
//   Flow: an accepted operand is written into the queue, taken into the
//   engine's command register, then emitted via the output register. '('
//   and an operator on an empty stack are pushed at once; otherwise an
//   operator, ')' or end beat pops entries one by one, each pop waiting on
//   the stack RAM's registered read. An end beat then emits its terminator.
//   Reset empties the stack, the queue and the output register and clears
//   the overflow flag. A stalled output holds its beat and halts the engine
//   in emit states; the queue keeps taking input until it fills.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_is_end,
    input  logic [7:0] i_in_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_last,
    output logic       o_overflow
);
    import itp_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_wdata;
    t_cmd q_head;

    // classify and enqueue
    itp_front u_front (
        .i_valid   (i_valid),
        .i_is_end  (i_is_end),
        .i_in_char (i_in_char),
        .i_q_full  (q_full),
        .o_stall   (o_stall),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    // decouple front from back
    itp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // run commands against the stack, drive output beats
    itp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_head   (q_head),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_char (o_out_char),
        .o_last     (o_last),
        .o_overflow (o_overflow)
    );

    // never write into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    // never read an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    // an accepted operand beat is queued by the next cycle
    a_operand_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_is_end && is_operand(i_in_char)) |=> !q_empty)
        else $error("accepted operand beat lost");

endmodule

FILE: rtl/core/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Input side: accept beats, classify each character, drop the ignored ones.
// ----------------------------------------------------------------------------
module itp_front (
    input  logic          i_valid,
    input  logic          i_is_end,
    input  logic [7:0]    i_in_char,
    input  logic          i_q_full,
    output logic          o_stall,
    output logic          o_q_push,
    output itp_pkg::t_cmd o_q_data
);
    import itp_pkg::*;

    logic       keep;
    t_kind      kind;
    logic [1:0] prec;

    always_comb begin
        prec = prec_of(i_in_char);
        keep = 1'b1;
        kind = K_END;
        if (i_is_end) begin
            kind = K_END;
        end else if (is_operand(i_in_char)) begin
            kind = K_OPERAND;
        end else if (i_in_char == CH_OPEN) begin
            kind = K_OPEN;
        end else if (i_in_char == CH_CLOSE) begin
            kind = K_CLOSE;
        end else if (prec != PREC_NONE) begin
            kind = K_OPER;
        end else begin
            keep = 1'b0;
        end
    end

    assign o_stall       = i_q_full;
    assign o_q_push      = i_valid && !i_q_full && keep;
    assign o_q_data.kind = kind;
    assign o_q_data.ch   = i_in_char;
    assign o_q_data.prec = prec;

endmodule

FILE: rtl/core/itp_queue.sv
// ----------------------------------------------------------------------------
// itp_queue
// Short command FIFO that decouples the classifier from the stack engine.
// ----------------------------------------------------------------------------
module itp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  itp_pkg::t_cmd i_data,
    input  logic          i_pop,
    output itp_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);
    import itp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/core/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// Stack engine: runs queued commands against the operator stack and drives
// the output register.
// ----------------------------------------------------------------------------
module itp_back #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itp_pkg::t_cmd i_q_head,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_char,
    output logic          o_last,
    output logic          o_overflow
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        B_IDLE,
        B_WAIT,
        B_TOP,
        B_EMIT,
        B_PUSH,
        B_TERM
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_char, n_out_char;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          out_free;
    logic          full;
    logic [CW-1:0] cnt_dec;
    logic [7:0]    top;
    logic [1:0]    top_prec;
    logic          push_req;
    logic [7:0]    push_char;
    logic          emit;
    logic [7:0]    emit_char;
    logic          emit_last;
    logic          ram_we;

    assign out_free = !r_out_valid || !i_stall;
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign cnt_dec  = r_count - CW'(1);
    assign top_prec = prec_of(top);
    assign ram_we   = push_req && !full;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (push_char),
        .i_raddr (cnt_dec[AW-1:0]),
        .o_rdata (top)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_count   = r_count;
        n_ovf     = r_ovf;
        o_q_pop   = 1'b0;
        push_req  = 1'b0;
        push_char = r_cmd.ch;
        emit      = 1'b0;
        emit_char = top;
        emit_last = 1'b0;

        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    case (i_q_head.kind)
                        K_OPERAND: n_state = B_EMIT;
                        K_OPEN: begin
                            push_req  = 1'b1;
                            push_char = i_q_head.ch;
                        end
                        K_CLOSE: begin
                            if (r_count != '0) begin
                                n_state = B_TOP;
                            end
                        end
                        K_OPER: begin
                            if (r_count != '0) begin
                                n_state = B_TOP;
                            end else begin
                                push_req  = 1'b1;
                                push_char = i_q_head.ch;
                            end
                        end
                        K_END: n_state = (r_count != '0) ? B_TOP : B_TERM;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = r_cmd.ch;
                    n_state   = B_IDLE;
                end
            end
            B_WAIT: n_state = B_TOP;
            B_TOP: begin
                case (r_cmd.kind)
                    K_CLOSE: begin
                        if (top == CH_OPEN) begin
                            // drop the matching open paren
                            n_count = cnt_dec;
                            n_state = B_IDLE;
                        end else if (out_free) begin
                            emit    = 1'b1;
                            n_count = cnt_dec;
                            n_state = (cnt_dec == '0) ? B_IDLE : B_WAIT;
                        end
                    end
                    K_OPER: begin
                        if (r_cmd.prec <= top_prec) begin
                            if (out_free) begin
                                emit    = 1'b1;
                                n_count = cnt_dec;
                                n_state = (cnt_dec == '0) ? B_PUSH : B_WAIT;
                            end
                        end else begin
                            push_req = 1'b1;
                            n_state  = B_IDLE;
                        end
                    end
                    K_END: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_count = cnt_dec;
                            n_state = (cnt_dec == '0) ? B_TERM : B_WAIT;
                        end
                    end
                    default: n_state = B_IDLE;
                endcase
            end
            B_PUSH: begin
                push_req = 1'b1;
                n_state  = B_IDLE;
            end
            B_TERM: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_char = CH_NUL;
                    emit_last = 1'b1;
                    n_ovf     = 1'b0;
                    n_state   = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase

        // full stack: drop the push and flag it
        if (push_req) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end

        n_out_valid = emit || (r_out_valid && i_stall);
        n_out_char  = emit ? emit_char : r_out_char;
        n_out_last  = emit ? emit_last : r_out_last;
        n_out_ovf   = emit ? r_ovf     : r_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;
    assign o_overflow = r_out_ovf;

endmodule
